// ===== hdl/xxfc_pkg.sv =====
// shared types, constants and codes for the xon/xoff flow controller
package xxfc_pkg;

    // counter width of the received byte count path
    localparam int COUNT_BITS = 16;

    // width of the byte count fields on the ports
    localparam int BYTE_W    = 16;
    localparam int BYTE_BITS = (COUNT_BITS < BYTE_W) ? COUNT_BITS : BYTE_W;
    localparam logic [BYTE_W-1:0] BYTE_MASK = BYTE_W'((33'd1 << BYTE_BITS) - 33'd1);

    localparam int QUEUE_W  = 8;
    localparam int THRESH_W = 9;
    localparam int CHAR_W   = 8;
    localparam int REQ_W    = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CHAR_W-1:0] CH_XON         = 8'h11;
    localparam logic [CHAR_W-1:0] CH_XOFF        = 8'h13;
    localparam logic [CHAR_W-1:0] SEVEN_BIT_MASK = 8'h7F;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RXCHAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOW_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_HIGH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_LOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BYTE_HIGH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BYTE_LOW    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESEND_GAP  = 3'd5;

    // configuration reset values
    localparam logic [THRESH_W-1:0] QUEUE_HIGH_RST = 9'd8;
    localparam logic [THRESH_W-1:0] QUEUE_LOW_RST  = 9'd2;
    localparam logic [BYTE_W-1:0]   BYTE_HIGH_RST  = 16'd1024;
    localparam logic [BYTE_W-1:0]   BYTE_LOW_RST   = 16'd256;
    localparam logic [BYTE_W-1:0]   RESEND_GAP_RST = 16'd100;

    typedef struct packed {
        logic                flow_enable;
        logic [THRESH_W-1:0] queue_high;
        logic [THRESH_W-1:0] queue_low;
        logic [BYTE_W-1:0]   byte_high;
        logic [BYTE_W-1:0]   byte_low;
        logic [BYTE_W-1:0]   resend_gap;
    } flow_cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [QUEUE_W-1:0] in_queue_count;
        logic [QUEUE_W-1:0] out_queue_count;
        logic [BYTE_W-1:0]  in_byte_count;
        logic [CHAR_W-1:0]  rx_char;
    } flow_req_t;

    typedef struct packed {
        logic              sent_xoff;
        logic [BYTE_W-1:0] xoff_mark;
        logic              peer_hold;
    } flow_state_t;

    typedef struct packed {
        logic              send_valid;
        logic [CHAR_W-1:0] send_char;
        logic              char_eaten;
        logic              output_allowed;
        logic              remote_held;
    } flow_result_t;

endpackage

// ===== hdl/xxfc_decide.sv =====
// single pass decision logic: thresholds, resend and partner character handling
module xxfc_decide (
    input  xxfc_pkg::flow_cfg_t    cfg,
    input  xxfc_pkg::flow_state_t  state_cur,
    input  xxfc_pkg::flow_req_t    req,
    output xxfc_pkg::flow_state_t  state_new,
    output xxfc_pkg::flow_result_t result
);
    import xxfc_pkg::*;

    logic [THRESH_W-1:0] queued;
    logic [BYTE_W-1:0]   bytes;
    logic [BYTE_W:0]     resend_point;
    logic [CHAR_W-1:0]   rxc;
    logic                over_high;
    logic                under_low;

    assign queued       = THRESH_W'(req.in_queue_count) + THRESH_W'(req.out_queue_count);
    assign bytes        = req.in_byte_count & BYTE_MASK;
    assign resend_point = {1'b0, state_cur.xoff_mark} + {1'b0, cfg.resend_gap};
    assign rxc          = req.rx_char & SEVEN_BIT_MASK;
    assign over_high    = (queued >= cfg.queue_high) || (bytes >= cfg.byte_high);
    assign under_low    = (queued < cfg.queue_low) && (bytes < cfg.byte_low);

    logic              send_valid;
    logic [CHAR_W-1:0] send_char;
    logic              eaten;

    always_comb begin
        state_new  = state_cur;
        send_valid = 1'b0;
        send_char  = '0;
        eaten      = 1'b0;
        if (cfg.flow_enable) begin
            unique case (req.req_type)
                REQ_CHECK, REQ_FLUSH: begin
                    if (!state_cur.sent_xoff) begin
                        if (over_high) begin
                            state_new.sent_xoff = 1'b1;
                            state_new.xoff_mark = bytes;
                            send_valid          = 1'b1;
                            send_char           = CH_XOFF;
                        end
                    end else if ((req.req_type == REQ_FLUSH) || under_low) begin
                        state_new.sent_xoff = 1'b0;
                        state_new.xoff_mark = '0;
                        send_valid          = 1'b1;
                        send_char           = CH_XON;
                    end else if ({1'b0, bytes} > resend_point) begin
                        state_new.xoff_mark = bytes;
                        send_valid          = 1'b1;
                        send_char           = CH_XOFF;
                    end
                end
                REQ_RXCHAR: begin
                    if (state_cur.peer_hold && (rxc == CH_XON)) begin
                        state_new.peer_hold = 1'b0;
                        eaten               = 1'b1;
                    end
                    if (rxc == CH_XOFF) begin
                        state_new.peer_hold = 1'b1;
                        eaten               = 1'b1;
                    end
                end
                default: begin
                    // unused request code leaves everything alone
                end
            endcase
        end
    end

    always_comb begin
        result.send_valid     = send_valid;
        result.send_char      = send_char;
        result.char_eaten     = eaten;
        result.output_allowed = !state_new.peer_hold;
        result.remote_held    = state_new.sent_xoff;
    end

endmodule

// ===== hdl/xon_xoff_flow_controller.sv =====
// top level of the xon/xoff flow controller: ports, config, pipeline and state
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tuser req_type, s_tdata counts and rx char
//  m_        out        m_tvalid / m_tready  m_tdata send flag, char and status flags
//  cfg_      in         cfg_wr_en            cfg_addr index, cfg_wdata value
//
// one transaction per clock while m_tready is high; input register then result
// register, the decision logic sits between them and updates the flow state as the
// transaction moves into the result register
// aresetn is synchronous, active low: clears both valid flags, the flow state and
// loads the configuration reset values
// a stalled result holds in the result register while the input register still takes
// one more transaction; s_tready drops only when both are full
module xon_xoff_flow_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [xxfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [xxfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // event stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] req_type
    input  logic [1:0]                      s_tuser,
    // [7:0] in_queue_count, [15:8] out_queue_count, [31:16] in_byte_count,
    // [39:32] rx_char
    input  logic [39:0]                     s_tdata,
    // result stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] send_valid, [8:1] send_char, [9] char_eaten, [10] output_allowed,
    // [11] remote_held, [15:12] zero
    output logic [15:0]                     m_tdata
);
    import xxfc_pkg::*;

    // configuration registers
    flow_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FLOW_ENABLE: cfg_next.flow_enable = cfg_wdata[0];
                CFG_QUEUE_HIGH:  cfg_next.queue_high  = cfg_wdata[THRESH_W-1:0];
                CFG_QUEUE_LOW:   cfg_next.queue_low   = cfg_wdata[THRESH_W-1:0];
                CFG_BYTE_HIGH:   cfg_next.byte_high   = cfg_wdata[BYTE_W-1:0];
                CFG_BYTE_LOW:    cfg_next.byte_low    = cfg_wdata[BYTE_W-1:0];
                CFG_RESEND_GAP:  cfg_next.resend_gap  = cfg_wdata[BYTE_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flow_enable <= 1'b0;
            cfg_reg.queue_high  <= QUEUE_HIGH_RST;
            cfg_reg.queue_low   <= QUEUE_LOW_RST;
            cfg_reg.byte_high   <= BYTE_HIGH_RST;
            cfg_reg.byte_low    <= BYTE_LOW_RST;
            cfg_reg.resend_gap  <= RESEND_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    logic      in_valid_reg, in_valid_next;
    flow_req_t in_req_reg, in_req_next;
    logic      s_take;
    logic      out_load;

    // result register
    logic         out_valid_reg, out_valid_next;
    flow_result_t out_res_reg, out_res_next;

    // flow state
    flow_state_t state_reg, state_next;
    flow_state_t state_dec;
    flow_result_t res_dec;

    // result register frees when empty or when its transaction is taken this cycle
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_take   = s_tvalid && s_tready;

    xxfc_decide u_decide (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .req       (in_req_reg),
        .state_new (state_dec),
        .result    (res_dec)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_req_next   = in_req_reg;
        if (s_take) begin
            in_valid_next               = 1'b1;
            in_req_next.req_type        = s_tuser;
            in_req_next.in_queue_count  = s_tdata[7:0];
            in_req_next.out_queue_count = s_tdata[15:8];
            in_req_next.in_byte_count   = s_tdata[31:16];
            in_req_next.rx_char         = s_tdata[39:32];
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        state_next     = state_reg;
        if (out_load) begin
            // state moves on exactly once per transaction, in arrival order
            out_valid_next = 1'b1;
            out_res_next   = res_dec;
            state_next     = state_dec;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        in_req_reg  <= in_req_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.remote_held,
                       out_res_reg.output_allowed,
                       out_res_reg.char_eaten,
                       out_res_reg.send_char,
                       out_res_reg.send_valid};

`ifndef SYNTHESIS
    // a requested flow character is always xon or xoff
    a_send_char_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.send_valid) |->
            ((out_res_reg.send_char == CH_XON) || (out_res_reg.send_char == CH_XOFF)))
        else $error("send_char is neither xon nor xoff");

    // the xoff mark is only kept while the partner is held
    a_mark_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.sent_xoff |-> (state_reg.xoff_mark == '0))
        else $error("xoff_mark set while no xoff outstanding");

    // with flow control disabled the flow state does not move
    a_disabled_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_reg.flow_enable |=> ($stable(state_reg.sent_xoff) && $stable(state_reg.peer_hold)
                                  && $stable(state_reg.xoff_mark)))
        else $error("flow state changed while disabled");

    // a consumed partner character never asks for a send in the same result
    a_eaten_no_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.char_eaten) |-> !out_res_reg.send_valid)
        else $error("eaten character result also requests a send");

    // the result register is not overwritten while a stalled result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("stalled result overwritten");
`endif

endmodule
